// ===== rtl/core/tplc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-point calibration package
// Shared constants and types for the two-point gain and offset calibration.
// ----------------------------------------------------------------------------
package tplc_pkg;

  localparam int SampleBitsDef = 16;

  localparam logic [15:0] Unity   = 16'd10000;
  localparam logic [15:0] GainMin = 16'd5000;
  localparam logic [15:0] GainMax = 16'd20000;
  localparam int          OffsLim = 500;

  // Every quotient that reaches an output is below 2^15 on the accepted path.
  localparam int DivQBits = 15;
  localparam int DivNumW  = 33;
  localparam int DivDenW  = 17;

  // Decisions and pass-through values that ride alongside the dividers.
  typedef struct packed {
    logic               rej;
    logic               gfb;
    logic               ofb;
    logic               zneg;
    logic               cneg;
    logic [15:0]        g;
    logic signed [15:0] o;
  } side_t;

endpackage

// ===== rtl/core/two_point_linear_calibration_unit.sv =====
// ----------------------------------------------------------------------------
// Two-point linear calibration unit
// Derives a new gain and offset correction from two calibration points.
// ----------------------------------------------------------------------------
// Usage: a request carries two calibration points (measured and true
// readings) and the gain and offset now in use. It is taken on the in_
// channel when in_valid is high and in_stall is low; the corrected gain,
// offset and error flag leave on the out_ channel in the same way.
// A result passes through four arithmetic stages, fifteen divider stages
// (one quotient bit each) and the output register before it is shown.
// A new request may enter every cycle while no stalled result holds the
// pipeline, so the throughput is then one item per cycle; the
// bit-per-stage dividers make up most of the pipeline.
// Reset (synchronous, rst_n low) clears every valid bit, so nothing in
// flight survives it. When the receiver stalls a valid result, the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_point_linear_calibration_unit #(
  parameter int SAMPLE_BITS = tplc_pkg::SampleBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_low_measured,
  input  logic [15:0]        in_low_true,
  input  logic [15:0]        in_high_measured,
  input  logic [15:0]        in_high_true,
  input  logic [15:0]        in_prev_gain,
  input  logic signed [15:0] in_prev_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_new_gain,
  output logic signed [15:0] out_new_offset,
  output logic               out_cal_error
);

  localparam int QW = tplc_pkg::DivQBits;
  localparam int NW = tplc_pkg::DivNumW;
  localparam int DW = tplc_pkg::DivDenW;
  localparam int EffBits = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam logic [15:0] SMask = 16'((32'd1 << EffBits) - 32'd1);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage A: masking, ordering checks, cross products.
  logic [15:0] lm, lt, hm, ht;
  assign lm = in_low_measured & SMask;
  assign lt = in_low_true & SMask;
  assign hm = in_high_measured & SMask;
  assign ht = in_high_true & SMask;

  logic               va_r, rej_a_r;
  logic [15:0]        dm_a_r, ds_a_r, g_a_r;
  logic signed [15:0] o_a_r;
  logic [31:0]        p1_a_r, p2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej_a_r <= (hm <= lm) || (ht <= lt);
      dm_a_r  <= hm - lm;
      ds_a_r  <= ht - lt;
      p1_a_r  <= 32'(lm) * 32'(ht);
      p2_a_r  <= 32'(hm) * 32'(lt);
      g_a_r   <= in_prev_gain;
      o_a_r   <= in_prev_offset;
    end
  end

  // Stage B: slope window, intercept magnitude and the scaled bounds.
  logic               vb_r, rej_b_r, neg_b_r;
  logic [31:0]        mag_b_r, gds_b_r;
  logic [24:0]        ds500_b_r;
  logic [30:0]        dm20k_b_r;
  logic [28:0]        dm5k_b_r;
  logic [29:0]        ds10k_b_r;
  logic signed [32:0] ods_b_r;
  logic [15:0]        dm_b_r, ds_b_r, g_b_r;
  logic signed [15:0] o_b_r;
  logic signed [32:0] o_ext_a, ds_ext_a;

  assign o_ext_a  = 33'(o_a_r);
  assign ds_ext_a = $signed({17'd0, ds_a_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej_b_r   <= rej_a_r || ({1'b0, dm_a_r} > {ds_a_r, 1'b0}) ||
                   ({dm_a_r, 1'b0} < {1'b0, ds_a_r});
      neg_b_r   <= p1_a_r < p2_a_r;
      mag_b_r   <= (p1_a_r < p2_a_r) ? (p2_a_r - p1_a_r) : (p1_a_r - p2_a_r);
      gds_b_r   <= 32'(g_a_r) * 32'(ds_a_r);
      ds500_b_r <= 25'(ds_a_r) * 25'(tplc_pkg::OffsLim);
      dm20k_b_r <= 31'(dm_a_r) * 31'(tplc_pkg::GainMax);
      dm5k_b_r  <= 29'(dm_a_r) * 29'(tplc_pkg::GainMin);
      ds10k_b_r <= 30'(ds_a_r) * 30'(tplc_pkg::Unity);
      ods_b_r   <= o_ext_a * ds_ext_a;
      dm_b_r    <= dm_a_r;
      ds_b_r    <= ds_a_r;
      g_b_r     <= g_a_r;
      o_b_r     <= o_a_r;
    end
  end

  // Stage C: intercept window, gain decision, combined offset numerator.
  logic               vc_r, rej_c_r, gfb_c_r, ofbo_c_r, neg_c_r;
  logic [31:0]        mag_c_r, gnum_c_r;
  logic signed [33:0] c_c_r;
  logic [24:0]        ds500_c_r;
  logic [15:0]        dm_c_r, ds_c_r, g_c_r;
  logic signed [15:0] o_c_r;
  logic signed [33:0] n_b, mag_s_b;
  logic               gfb_b;

  assign mag_s_b = $signed({2'b00, mag_b_r});
  assign n_b     = neg_b_r ? -mag_s_b : mag_s_b;
  assign gfb_b   = (g_b_r > tplc_pkg::GainMax) || (g_b_r < tplc_pkg::GainMin) ||
                   (gds_b_r > 32'(dm20k_b_r)) || (gds_b_r < 32'(dm5k_b_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej_c_r   <= rej_b_r || (mag_b_r > 32'(ds500_b_r));
      gfb_c_r   <= gfb_b;
      gnum_c_r  <= gfb_b ? 32'(ds10k_b_r) : gds_b_r;
      ofbo_c_r  <= (o_b_r > 16'sd500) || (o_b_r < -16'sd500);
      c_c_r     <= 34'(ods_b_r) - n_b;
      neg_c_r   <= neg_b_r;
      mag_c_r   <= mag_b_r;
      ds500_c_r <= ds500_b_r;
      dm_c_r    <= dm_b_r;
      ds_c_r    <= ds_b_r;
      g_c_r     <= g_b_r;
      o_c_r     <= o_b_r;
    end
  end

  // Stage D: offset decision and divider operands.
  logic               vd_r;
  tplc_pkg::side_t    side_d_r;
  logic [NW-1:0]      zn_d_r, gn_d_r, cn_d_r;
  logic [DW-1:0]      dsd_d_r, dmd_d_r;
  logic signed [33:0] lim_c, cabs_c;

  assign lim_c  = $signed({9'd0, ds500_c_r});
  assign cabs_c = (c_c_r < 0) ? -c_c_r : c_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r.rej  <= rej_c_r;
      side_d_r.gfb  <= gfb_c_r;
      side_d_r.ofb  <= ofbo_c_r || (c_c_r > lim_c) || (c_c_r < -lim_c);
      side_d_r.zneg <= neg_c_r;
      side_d_r.cneg <= c_c_r < 0;
      side_d_r.g    <= g_c_r;
      side_d_r.o    <= o_c_r;
      zn_d_r        <= NW'(mag_c_r);
      gn_d_r        <= NW'(gnum_c_r);
      cn_d_r        <= cabs_c[NW-1:0];
      dsd_d_r       <= DW'(ds_c_r);
      dmd_d_r       <= DW'(dm_c_r);
    end
  end

  // Divider stages: three quotients in lockstep.
  logic [QW-1:0] zq, gq, cq;

  tplc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_z (
    .clk(clk), .en(en), .num(zn_d_r), .den(dsd_d_r), .quo(zq)
  );
  tplc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_g (
    .clk(clk), .en(en), .num(gn_d_r), .den(dmd_d_r), .quo(gq)
  );
  tplc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_c (
    .clk(clk), .en(en), .num(cn_d_r), .den(dsd_d_r), .quo(cq)
  );

  logic            vq_r   [QW];
  tplc_pkg::side_t side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[i] <= 1'b0;
      end else if (en) begin
        vq_r[i] <= (i == 0) ? vd_r : vq_r[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= (i == 0) ? side_d_r : side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Output register and result selection.
  tplc_pkg::side_t    sq;
  logic [15:0]        zq16, cq16;
  logic signed [15:0] offs_sel;
  logic [15:0]        gain_sel;
  logic               out_valid_r, err_r;
  logic [15:0]        gain_r;
  logic signed [15:0] offs_r;

  assign sq   = side_r[QW-1];
  assign zq16 = 16'(zq);
  assign cq16 = 16'(cq);

  always_comb begin
    gain_sel = sq.rej ? sq.g : 16'(gq);
    if (sq.rej) begin
      offs_sel = sq.o;
    end else if (sq.ofb) begin
      // The fresh correction is minus the intercept.
      offs_sel = sq.zneg ? $signed(zq16) : -$signed(zq16);
    end else begin
      offs_sel = sq.cneg ? -$signed(cq16) : $signed(cq16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vq_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gain_r <= gain_sel;
      offs_r <= offs_sel;
      err_r  <= sq.rej || sq.gfb || sq.ofb;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_gain   = gain_r;
  assign out_new_offset = offs_r;
  assign out_cal_error  = err_r;

endmodule

// ===== rtl/core/tplc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division that resolves one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tplc_div #(
  parameter int NW = tplc_pkg::DivNumW,
  parameter int DW = tplc_pkg::DivDenW,
  parameter int QW = tplc_pkg::DivQBits
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [TW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] dsh;
    logic [TW-1:0] diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = TW'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = TW'(rem_r[i-1]);
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign dsh  = TW'(den_in) << K;
    assign ge   = (rem_in >= dsh);
    assign diff = rem_in - dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? NW'(diff) : NW'(rem_in);
        den_r[i] <= den_in;
        quo_r[i] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ===== rtl/core/tplc_checker.sv =====
// ----------------------------------------------------------------------------
// Two-point calibration checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tplc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_new_gain,
  input logic signed [15:0] out_new_offset,
  input logic               out_cal_error
);

  // A result without error always carries a gain inside its window.
  a_gain_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cal_error |->
      out_new_gain >= tplc_pkg::GainMin && out_new_gain <= tplc_pkg::GainMax)
    else $error("clean result with gain outside its window");

  // A result without error always carries an offset inside its window.
  a_offs_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cal_error |->
      out_new_offset >= -16'sd500 && out_new_offset <= 16'sd500)
    else $error("clean result with offset outside its window");

  // The input side is held exactly while a shown result is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_new_gain) && $stable(out_new_offset) &&
      $stable(out_cal_error))
    else $error("stalled result changed");

endmodule

bind two_point_linear_calibration_unit tplc_checker u_tplc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_new_gain(out_new_gain),
  .out_new_offset(out_new_offset), .out_cal_error(out_cal_error)
);

// ===== test/tb_two_point_linear_calibration_unit.sv =====
// ----------------------------------------------------------------------------
// Two-point linear calibration unit testbench
// Drives directed and random calibration requests through the unit with
// random idling on both channels, and compares every result transfer with
// an exact integer prediction of the new gain, offset and error flag.
// ----------------------------------------------------------------------------
module tb_two_point_linear_calibration_unit;

  typedef struct {
    logic [15:0]        lm;
    logic [15:0]        lt;
    logic [15:0]        hm;
    logic [15:0]        ht;
    logic [15:0]        g;
    logic signed [15:0] o;
  } cal_req_t;

  typedef struct {
    logic [15:0]        gain;
    logic signed [15:0] offs;
    logic               err;
  } cal_res_t;

  typedef struct {
    cal_req_t req;
    logic     known;
    cal_res_t res;
  } cal_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        in_low_measured;
  logic [15:0]        in_low_true;
  logic [15:0]        in_high_measured;
  logic [15:0]        in_high_true;
  logic [15:0]        in_prev_gain;
  logic signed [15:0] in_prev_offset;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_new_gain;
  logic signed [15:0] out_new_offset;
  logic               out_cal_error;

  cal_res_t pending_results[$];
  int       n_fail;
  int       n_results;
  int       n_rejected;
  int       n_clean;
  bit       calm;

  two_point_linear_calibration_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_low_measured  (in_low_measured),
    .in_low_true      (in_low_true),
    .in_high_measured (in_high_measured),
    .in_high_true     (in_high_true),
    .in_prev_gain     (in_prev_gain),
    .in_prev_offset   (in_prev_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_gain     (out_new_gain),
    .out_new_offset   (out_new_offset),
    .out_cal_error    (out_cal_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL two_point_linear_calibration_unit");
    $finish;
  end

  // Exact integer calibration; every quotient truncates toward zero.
  function automatic cal_res_t calibrate(cal_req_t r);
    cal_res_t    res;
    longint      lm, lt, hm, ht, g, o, dm, ds, p1, p2, mag, q, rm, n, c;
    bit          neg;
    bit          err;
    lm = longint'(r.lm);
    lt = longint'(r.lt);
    hm = longint'(r.hm);
    ht = longint'(r.ht);
    g = longint'(r.g);
    o = longint'(r.o);
    res.gain = r.g;
    res.offs = r.o;
    res.err = 1'b1;
    err = 1'b0;
    if (hm < lm || ht < lt || hm == 0 || ht == 0 || hm == lm || ht == lt) return res;
    dm = hm - lm;
    ds = ht - lt;
    if (dm > 2 * ds || 2 * dm < ds) return res;
    p1 = lm * ht;
    p2 = hm * lt;
    neg = p1 < p2;
    mag = neg ? p2 - p1 : p1 - p2;
    q = mag / ds;
    rm = mag % ds;
    if (q > 500 || (q == 500 && rm != 0)) return res;
    n = neg ? -mag : mag;
    if (g > 20000 || g < 5000 || g * ds > 20000 * dm || g * ds < 5000 * dm) begin
      res.gain = 16'((10000 * ds) / dm);
      err = 1'b1;
    end else begin
      res.gain = 16'((g * ds) / dm);
    end
    c = o * ds - n;
    if (o > 500 || o < -500 || c > 500 * ds || c < -500 * ds) begin
      res.offs = 16'(neg ? q : -q);
      err = 1'b1;
    end else begin
      res.offs = 16'(c / ds);
    end
    res.err = err;
    return res;
  endfunction

  function automatic cal_req_t mk(int lm, int lt, int hm, int ht, int g, int o);
    cal_req_t r;
    r.lm = 16'(lm);
    r.lt = 16'(lt);
    r.hm = 16'(hm);
    r.ht = 16'(ht);
    r.g = 16'(g);
    r.o = 16'(o);
    return r;
  endfunction

  function automatic cal_row_t row(cal_req_t r, bit known, int g, int o, bit e);
    cal_row_t x;
    x.req = r;
    x.known = known;
    x.res.gain = 16'(g);
    x.res.offs = 16'(o);
    x.res.err = e;
    return x;
  endfunction

  // Mostly well-formed point pairs near unity slope with small intercept.
  function automatic cal_req_t rand_req();
    cal_req_t r;
    int       lm, lt, hm, ht, sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      r.lm = 16'($urandom);
      r.lt = 16'($urandom);
      r.hm = 16'($urandom);
      r.ht = 16'($urandom);
    end else begin
      lt = $urandom_range(0, 40000);
      ht = lt + $urandom_range(1, 25000);
      if (sel < 70) begin
        lm = lt + $urandom_range(0, 600) - 300;
        hm = lm + ((ht - lt) * $urandom_range(80, 125)) / 100;
      end else begin
        lm = lt + $urandom_range(0, 1400) - 700;
        hm = lm + ((ht - lt) * $urandom_range(40, 210)) / 100;
      end
      if (lm < 0) lm = 0;
      if (hm > 65535) hm = 65535;
      r.lm = 16'(lm);
      r.lt = 16'(lt);
      r.hm = 16'(hm);
      r.ht = 16'(ht);
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      r.g = 16'($urandom_range(4500, 21000));
      r.o = 16'($signed($urandom_range(0, 1100)) - 550);
    end else begin
      r.g = 16'($urandom);
      r.o = 16'($urandom);
    end
    return r;
  endfunction

  task automatic send(cal_req_t r);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_low_measured  <= r.lm;
    in_low_true      <= r.lt;
    in_high_measured <= r.hm;
    in_high_true     <= r.ht;
    in_prev_gain     <= r.g;
    in_prev_offset   <= r.o;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: random stall and comparison against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          n_fail <= n_fail + 1;
        end else begin
          cal_res_t e;
          e = pending_results.pop_front();
          if (out_cal_error) n_rejected <= n_rejected + 1;
          else n_clean <= n_clean + 1;
          if (out_new_gain !== e.gain) begin
            $error("new_gain expected %0d actual %0d", e.gain, out_new_gain);
            n_fail <= n_fail + 1;
          end
          if (out_new_offset !== e.offs) begin
            $error("new_offset expected %0d actual %0d", e.offs, out_new_offset);
            n_fail <= n_fail + 1;
          end
          if (out_cal_error !== e.err) begin
            $error("cal_error expected %0d actual %0d", e.err, out_cal_error);
            n_fail <= n_fail + 1;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  initial begin
    cal_row_t directed[$];
    cal_row_t x;
    cal_req_t r;
    cal_res_t p;
    int       wait_cyc;
    n_fail = 0;
    n_results = 0;
    n_rejected = 0;
    n_clean = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_low_measured = '0;
    in_low_true = '0;
    in_high_measured = '0;
    in_high_true = '0;
    in_prev_gain = '0;
    in_prev_offset = '0;
    // Rejections pass the previous correction straight through.
    directed.push_back(row(mk(0, 0, 0, 0, 0, 0), 1, 0, 0, 1));
    directed.push_back(row(mk(65535, 65535, 65535, 65535, 65535, -1), 1, 65535, -1, 1));
    directed.push_back(row(mk(200, 100, 100, 300, 10000, 5), 1, 10000, 5, 1));
    directed.push_back(row(mk(100, 300, 200, 100, 10000, 5), 1, 10000, 5, 1));
    directed.push_back(row(mk(100, 100, 100, 300, 12345, -7), 1, 12345, -7, 1));
    directed.push_back(row(mk(100, 100, 300, 100, 12345, -7), 1, 12345, -7, 1));
    directed.push_back(row(mk(0, 0, 500, 100, 10000, 0), 1, 10000, 0, 1));
    directed.push_back(row(mk(0, 0, 100, 500, 10000, 0), 1, 10000, 0, 1));
    directed.push_back(row(mk(1000, 0, 2000, 1000, 9000, 3), 1, 9000, 3, 1));
    directed.push_back(row(mk(0, 0, 0, 100, 10000, 0), 1, 10000, 0, 1));
    // Identity points with unity correction give unity back.
    directed.push_back(row(mk(0, 0, 1000, 1000, 10000, 0), 1, 10000, 0, 0));
    directed.push_back(row(mk(0, 0, 65535, 65535, 10000, 0), 1, 10000, 0, 0));
    // Slope exactly two and exactly one half, intercept at the limits.
    directed.push_back(row(mk(0, 0, 2000, 1000, 10000, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 2000, 10000, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(500, 0, 1500, 1000, 10000, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 500, 1000, 1500, 10000, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(501, 0, 1501, 1000, 10000, 0), 0, 0, 0, 0));
    // Gain and offset fallbacks, previous values at and beyond the edges.
    directed.push_back(row(mk(0, 0, 1000, 1000, 4999, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 1000, 20001, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 1000, 5000, 500), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 1000, 20000, -500), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 1000, 10000, 501), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1000, 1000, 10000, -32768), 0, 0, 0, 0));
    directed.push_back(row(mk(0, 0, 1500, 1000, 16000, 0), 0, 0, 0, 0));
    directed.push_back(row(mk(300, 0, 1300, 1000, 10000, -300), 0, 0, 0, 0));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      x = directed[i];
      if (x.known) begin
        p = calibrate(x.req);
        if (p.gain !== x.res.gain || p.offs !== x.res.offs || p.err !== x.res.err) begin
          $error("directed row %0d disagrees with the prediction", i);
          n_fail = n_fail + 1;
        end
        pending_results.push_back(x.res);
      end else begin
        pending_results.push_back(calibrate(x.req));
      end
      send(x.req);
    end
    for (int i = 0; i < 1600; i++) begin
      calm = (i >= 600 && i < 900);
      r = rand_req();
      pending_results.push_back(calibrate(r));
      send(r);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    wait_cyc = 0;
    while (pending_results.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (40) @(posedge clk);
    $display("Ran %0d calibration requests, %0d results seen.",
             directed.size() + 1600, n_results);
    $display("Clean results %0d, flagged results %0d.", n_clean, n_rejected);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("PASS two_point_linear_calibration_unit");
    end else begin
      $display("FAIL two_point_linear_calibration_unit");
    end
    $finish;
  end

endmodule
